// File: design/vkl_pkg.sv
`default_nettype none
package vkl_pkg;

    // key table geometry
    localparam int KEY_AW   = 6;
    localparam int MAX_KEYS = 64;
    localparam int CNT_W    = 7;

    // fraction is Q0.31, one quotient bit per divider step
    localparam int FRAC_W    = 31;
    localparam int DIV_STEPS = FRAC_W;

    // stream payload widths
    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 104;

    // request kinds carried on s_axis_tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // result status carried on m_axis_tuser
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BEFORE = 2'd1;
    localparam logic [1:0] STAT_AFTER  = 2'd2;
    localparam logic [1:0] STAT_EMPTY  = 2'd3;

    // register index (paddr[2])
    localparam logic REG_KEY_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_RESP
    } t_state;

    // one table entry as stored in the key memory
    typedef struct packed {
        logic        [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_key;

endpackage
`default_nettype wire

// File: design/vkl_div.sv
`default_nettype none
// Restoring divider: quotient = floor((num << 31) / den), num < den.
module vkl_div
    import vkl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [31:0]       i_num,
    input  wire logic [31:0]       i_den,
    output logic                   o_done,
    output logic [FRAC_W-1:0]      o_quo
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [31:0]       r_rem, n_rem;
    logic [31:0]       r_den, n_den;
    logic [FRAC_W-1:0] r_quo, n_quo;

    logic [32:0] sh;
    logic [32:0] diff;
    logic        ge;

    // one quotient bit per cycle
    always_comb begin
        sh     = {r_rem, 1'b0};
        diff   = sh - {1'b0, r_den};
        ge     = (sh >= {1'b0, r_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? diff[31:0] : sh[31:0];
            n_quo = {r_quo[FRAC_W-2:0], ge};
            n_cnt = r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

// File: design/vector_keyframe_lerp.sv
`default_nettype none
// Keyframe linear interpolator over a 64-entry table of (time, x, y, z) keys held in one
// synchronous memory. A write request (tuser 0) stores one key and leaves the block ready for
// the next request. A query request (tuser 1) scans the keys in order, one memory read per cycle,
// for the first key whose time is above the query time, then divides for the Q0.31 fraction and
// blends x, y and z on one shared 33x16 multiplier. A query scans up to key_count keys (at most
// 64), then runs the 31-step divide, then two partial products and a sum per component in the
// blend, and last posts the result; the next request is taken only after the result is posted.
// Clamped and empty results skip the divide and multiply. A result that is not taken holds the
// block. Status on m_axis_tuser: 0 ok, 1 clamped before start, 2 clamped after end, 3 no keys.
// key_count is at APB address 0; keys must be loaded before use.
module vector_keyframe_lerp
    import vkl_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // APB configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // request stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // key_index[5:0], key_time[37:6], key_x[69:38], key_y[101:70], key_z[133:102],
    // query_time[165:134], zero fill
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // mode[0]
    input  wire logic                s_axis_tuser,
    // result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], segment[101:96], zero fill
    output logic [M_DATA_W-1:0]      m_axis_tdata,
    // status[1:0]
    output logic [1:0]               m_axis_tuser
);

    // request fields
    logic [KEY_AW-1:0] in_index;
    logic [31:0]       in_time;
    logic [31:0]       in_x, in_y, in_z;
    logic [31:0]       in_query;

    assign in_index = s_axis_tdata[5:0];
    assign in_time  = s_axis_tdata[37:6];
    assign in_x     = s_axis_tdata[69:38];
    assign in_y     = s_axis_tdata[101:70];
    assign in_z     = s_axis_tdata[133:102];
    assign in_query = s_axis_tdata[165:134];

    // configuration register
    logic [CNT_W-1:0] r_key_count;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_KEY_COUNT);
    assign prdata = (paddr[2] == REG_KEY_COUNT) ? {25'd0, r_key_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
        end else if (cfg_wr) begin
            r_key_count <= pwdata[CNT_W-1:0];
        end
    end

    // control and datapath registers
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [31:0]       r_q, n_q;
    logic [KEY_AW-1:0] r_idx, n_idx;
    t_key              r_prev, n_prev;
    logic signed [32:0] r_dx, r_dy, r_dz, n_dx, n_dy, n_dz;
    logic [1:0]        r_comp, n_comp;
    logic [1:0]        r_ph, n_ph;
    logic signed [49:0] r_pp, n_pp;
    logic signed [63:0] r_acc, n_acc;
    logic [31:0]       r_res_x, r_res_y, r_res_z, n_res_x, n_res_y, n_res_z;
    logic [KEY_AW-1:0] r_res_seg, n_res_seg;
    logic [1:0]        r_res_stat, n_res_stat;
    logic              r_m_valid, n_m_valid;
    logic [M_DATA_W-1:0] r_m_data, n_m_data;
    logic [1:0]        r_m_user, n_m_user;

    // key memory: written only in idle, read every cycle (address 0 outside a scan), so a write can overlap a read
    t_key              r_key_mem [MAX_KEYS];
    t_key              r_rd_data;
    logic [KEY_AW-1:0] rd_addr;
    logic              s_acc;
    logic              mem_wr;
    t_key              wr_key;

    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign mem_wr = s_acc && (s_axis_tuser == MODE_WRITE);
    assign wr_key = '{t: in_time, x: in_x, y: in_y, z: in_z};
    assign rd_addr = (r_state == ST_SCAN) ? r_idx + KEY_AW'(1) : '0;

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_key_mem[in_index] <= wr_key;
        end
        r_rd_data <= r_key_mem[rd_addr];
    end

    // divider
    logic        div_start;
    logic        div_done;
    logic [FRAC_W-1:0] div_quo;
    logic [31:0] div_num, div_den;

    vkl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // shared multiplier: delta times one half of the fraction
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [31:0] a_sel;
    logic signed [63:0] blend;
    logic [31:0]        comp_val;

    always_comb begin
        case (r_comp)
            2'd0: begin
                mul_a = r_dx;
                a_sel = r_prev.x;
            end
            2'd1: begin
                mul_a = r_dy;
                a_sel = r_prev.y;
            end
            default: begin
                mul_a = r_dz;
                a_sel = r_prev.z;
            end
        endcase
        mul_b = (r_ph == 2'd0) ? {1'b0, div_quo[15:0]} : {2'b00, div_quo[30:16]};
        mul_p = mul_a * mul_b;
        // low partial plus high partial shifted up by 16, floor by 2^31
        blend    = r_acc + ({{14{r_pp[49]}}, r_pp} <<< 16);
        comp_val = a_sel + blend[62:31];
    end

    logic        out_free;
    logic [CNT_W-1:0] eff_n;
    t_key        cur;
    logic        last_key;

    assign out_free = !r_m_valid || m_axis_tready;
    assign eff_n    = (r_key_count > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : r_key_count;
    assign cur      = r_rd_data;
    assign last_key = ({1'b0, r_idx} == (r_n - CNT_W'(1)));
    assign s_axis_tready = (r_state == ST_IDLE);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_q        = r_q;
        n_idx      = r_idx;
        n_prev     = r_prev;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_dz       = r_dz;
        n_comp     = r_comp;
        n_ph       = r_ph;
        n_pp       = r_pp;
        n_acc      = r_acc;
        n_res_x    = r_res_x;
        n_res_y    = r_res_y;
        n_res_z    = r_res_z;
        n_res_seg  = r_res_seg;
        n_res_stat = r_res_stat;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_data   = r_m_data;
        n_m_user   = r_m_user;
        div_start  = 1'b0;
        div_num    = r_q - r_prev.t;
        div_den    = cur.t - r_prev.t;
        case (r_state)
            ST_IDLE: begin
                if (s_acc && (s_axis_tuser == MODE_QUERY)) begin
                    n_q   = in_query;
                    n_n   = eff_n;
                    n_idx = '0;
                    if (eff_n == '0) begin
                        n_res_x    = '0;
                        n_res_y    = '0;
                        n_res_z    = '0;
                        n_res_seg  = '0;
                        n_res_stat = STAT_EMPTY;
                        n_state    = ST_RESP;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_n == CNT_W'(1)) begin
                    // single key: return it as is
                    n_res_x    = cur.x;
                    n_res_y    = cur.y;
                    n_res_z    = cur.z;
                    n_res_seg  = '0;
                    n_res_stat = STAT_OK;
                    n_state    = ST_RESP;
                end else if (r_idx == '0) begin
                    n_prev = cur;
                    n_idx  = r_idx + KEY_AW'(1);
                end else if (r_q < cur.t) begin
                    if (r_q < r_prev.t) begin
                        // query before the segment start
                        n_res_x    = r_prev.x;
                        n_res_y    = r_prev.y;
                        n_res_z    = r_prev.z;
                        n_res_seg  = r_idx - KEY_AW'(1);
                        n_res_stat = STAT_BEFORE;
                        n_state    = ST_RESP;
                    end else begin
                        div_start = 1'b1;
                        n_dx      = {cur.x[31], cur.x} - {r_prev.x[31], r_prev.x};
                        n_dy      = {cur.y[31], cur.y} - {r_prev.y[31], r_prev.y};
                        n_dz      = {cur.z[31], cur.z} - {r_prev.z[31], r_prev.z};
                        n_state   = ST_DIV;
                    end
                end else if (last_key) begin
                    // past the last key
                    n_res_x    = cur.x;
                    n_res_y    = cur.y;
                    n_res_z    = cur.z;
                    n_res_seg  = r_idx;
                    n_res_stat = STAT_AFTER;
                    n_state    = ST_RESP;
                end else begin
                    n_prev = cur;
                    n_idx  = r_idx + KEY_AW'(1);
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_comp  = 2'd0;
                    n_ph    = 2'd0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                case (r_ph)
                    2'd0: begin
                        n_pp = mul_p;
                        n_ph = 2'd1;
                    end
                    2'd1: begin
                        n_acc = {{14{r_pp[49]}}, r_pp};
                        n_pp  = mul_p;
                        n_ph  = 2'd2;
                    end
                    default: begin
                        case (r_comp)
                            2'd0:    n_res_x = comp_val;
                            2'd1:    n_res_y = comp_val;
                            default: n_res_z = comp_val;
                        endcase
                        n_ph = 2'd0;
                        if (r_comp == 2'd2) begin
                            n_res_seg  = r_idx - KEY_AW'(1);
                            n_res_stat = STAT_OK;
                            n_state    = ST_RESP;
                        end else begin
                            n_comp = r_comp + 2'd1;
                        end
                    end
                endcase
            end
            ST_RESP: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {2'b00, r_res_seg, r_res_z, r_res_y, r_res_x};
                    n_m_user  = r_res_stat;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_q        <= n_q;
        r_idx      <= n_idx;
        r_prev     <= n_prev;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_dz       <= n_dz;
        r_comp     <= n_comp;
        r_ph       <= n_ph;
        r_pp       <= n_pp;
        r_acc      <= n_acc;
        r_res_x    <= n_res_x;
        r_res_y    <= n_res_y;
        r_res_z    <= n_res_z;
        r_res_seg  <= n_res_seg;
        r_res_stat <= n_res_stat;
        r_m_data   <= n_m_data;
        r_m_user   <= n_m_user;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule
`default_nettype wire

// File: design/vkl_chk.sv
`default_nettype none
// Port-level checks for the interpolator.
module vkl_chk
    import vkl_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    input  wire logic                s_axis_tready,
    input  wire logic                s_axis_tuser,
    input  wire logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    input  wire logic [M_DATA_W-1:0] m_axis_tdata,
    input  wire logic [1:0]          m_axis_tuser
);

    // a result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped before accept");

    // a query keeps the block busy on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_QUERY) |=> !s_axis_tready)
        else $error("query did not start work");

    // a key write leaves the input ready on the next cycle
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_WRITE) |=> s_axis_tready)
        else $error("key write stalled the input");

    // empty table result carries all-zero payload
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_EMPTY) |-> (m_axis_tdata[101:0] == '0))
        else $error("empty table result not zero");

endmodule

bind vector_keyframe_lerp vkl_chk u_vkl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// File: tb/vector_keyframe_lerp_test.sv
`default_nettype none
module vector_keyframe_lerp_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vkl_pkg::*;

    localparam int COUNT_TOP       = (1 << CNT_W) - 1;
    localparam int ITEMS_PER_PHASE = 510;
    localparam int SETTLE_CYCLES   = 16;
    localparam int DRAIN_CYCLES    = 100;
    localparam int HOLD_CYCLES     = 400;
    localparam int REPORT_LIMIT    = 10;

    // one interpolated result as it leaves the block
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [5:0]  seg;
        logic [1:0]  status;
    } lerp_result_t;

    // key table mirror and queue of awaited results
    class lerp_scoreboard;
        logic [31:0]      key_t [MAX_KEYS];
        logic [31:0]      key_x [MAX_KEYS];
        logic [31:0]      key_y [MAX_KEYS];
        logic [31:0]      key_z [MAX_KEYS];
        logic [CNT_W-1:0] key_count;
        lerp_result_t     awaited[$];
        int               mismatches;

        function new();
            key_count  = '0;
            mismatches = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] v);
            key_count = v;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function lerp_result_t key_result(int k, int seg, logic [1:0] st);
            lerp_result_t r;
            r.x      = key_x[k];
            r.y      = key_y[k];
            r.z      = key_z[k];
            r.seg    = seg[5:0];
            r.status = st;
            return r;
        endfunction

        // a + floor((b - a) * frac / 2^31), delta kept exact at 33 bits
        function logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [30:0] frac);
            longint delta;
            longint prod;
            delta = longint'($signed(b)) - longint'($signed(a));
            prod  = delta * longint'({1'b0, frac});
            prod  = prod >>> 31;
            return a + prod[31:0];
        endfunction

        function lerp_result_t interpolate_at(logic [31:0] q);
            lerp_result_t r;
            int           n;
            int           seg;
            logic [31:0]  t0;
            logic [31:0]  diff;
            logic [63:0]  quot;
            n = (key_count > MAX_KEYS) ? MAX_KEYS : int'(key_count);
            r = '0;
            if (n == 0) begin
                r.status = STAT_EMPTY;
                return r;
            end
            if (n == 1)
                return key_result(0, 0, STAT_OK);
            // first segment whose end key lies above the query time
            seg = 0;
            while (seg + 1 < n && q >= key_t[seg + 1])
                seg++;
            if (seg + 1 >= n)
                return key_result(n - 1, n - 1, STAT_AFTER);
            t0 = key_t[seg];
            if (q < t0)
                return key_result(seg, seg, STAT_BEFORE);
            diff = q - t0;
            quot = ({32'b0, diff} << 31) / {32'b0, key_t[seg + 1] - t0};
            r.x      = blend(key_x[seg], key_x[seg + 1], quot[30:0]);
            r.y      = blend(key_y[seg], key_y[seg + 1], quot[30:0]);
            r.z      = blend(key_z[seg], key_z[seg + 1], quot[30:0]);
            r.seg    = seg[5:0];
            r.status = STAT_OK;
            return r;
        endfunction

        function void note_request(logic mode, logic [S_DATA_W-1:0] d);
            logic [5:0] idx;
            idx = d[5:0];
            if (mode == MODE_WRITE) begin
                key_t[idx] = d[37:6];
                key_x[idx] = d[69:38];
                key_y[idx] = d[101:70];
                key_z[idx] = d[133:102];
            end else begin
                awaited.push_back(interpolate_at(d[165:134]));
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] d, logic [1:0] st);
            lerp_result_t got;
            lerp_result_t want;
            got.x      = d[31:0];
            got.y      = d[63:32];
            got.z      = d[95:64];
            got.seg    = d[101:96];
            got.status = st;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result x=%h y=%h z=%h seg=%0d status=%0d",
                             got.x, got.y, got.z, got.seg, got.status);
                return;
            end
            want = awaited.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.seg !== want.seg || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected x=%h y=%h z=%h seg=%0d status=%0d,",
                             want.x, want.y, want.z, want.seg, want.status,
                             " got x=%h y=%h z=%h seg=%0d status=%0d",
                             got.x, got.y, got.z, got.seg, got.status);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    lerp_scoreboard sb = new();

    int          snd_idle_pct = 35;
    int          rcv_idle_pct = 79;
    int          sent_items = 0;
    bit          hold_request = 1'b0;
    bit          table_full = 1'b0;
    logic [31:0] tbl_t [MAX_KEYS];

    int snd_plan [3] = '{35, 79, 0};
    int rcv_plan [3] = '{79, 35, 0};

    vector_keyframe_lerp dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watch both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // result side: random stalls, plus one long hold-off on demand
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_req(logic [5:0] idx, logic [31:0] t,
                                                     logic [31:0] x, logic [31:0] y,
                                                     logic [31:0] z, logic [31:0] q);
        return {{(S_DATA_W - 166){1'b0}}, q, z, y, x, t, idx};
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            default: return $urandom();
        endcase
    endfunction

    // query time: mostly inside a segment, some at keys, before the start and past the end
    function automatic logic [31:0] pick_query(int n);
        int          kind;
        int          i;
        logic [31:0] lo;
        logic [31:0] hi;
        kind = $urandom_range(0, 9);
        if (n < 2 || kind == 0)
            return $urandom();
        if (kind == 1)
            return tbl_t[$urandom_range(0, n - 1)];
        if (kind == 2)
            return tbl_t[n - 1] + $urandom_range(0, 3);
        if (kind == 3)
            return tbl_t[0] - $urandom_range(1, 3);
        i  = $urandom_range(0, n - 2);
        lo = tbl_t[i];
        hi = tbl_t[i + 1];
        if (hi > lo)
            return lo + ($urandom() % (hi - lo));
        return lo;
    endfunction

    task automatic send_req(input logic mode, input logic [S_DATA_W-1:0] data);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_key(input logic [5:0] idx, input logic [31:0] t, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
        send_req(MODE_WRITE, pack_req(idx, t, x, y, z, $urandom()));
        tbl_t[idx] = t;
    endtask

    task automatic send_query(input logic [31:0] q);
        send_req(MODE_QUERY, pack_req(KEY_AW'($urandom_range(0, 63)), $urandom(), $urandom(),
                                      $urandom(), $urandom(), q));
    endtask

    // stop offering, wait for every result, then let a trailing key write finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_key_count(input logic [CNT_W-1:0] v);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_KEY_COUNT, 2'b00};
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.set_count(v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // load a run of keys, pick a count, then query it
    task automatic run_sequence(input int n, input bit exact_count);
        int               style;
        int               k;
        int               n_q;
        int               eff;
        logic [31:0]      t;
        logic [31:0]      maxstep;
        logic [CNT_W-1:0] cnt;
        style   = $urandom_range(0, 7);
        t       = $urandom_range(0, 32'h0010_0000);
        maxstep = (style < 4) ? 32'h0004_0000 : (32'hFFFF_FFFF - t) / n;
        for (k = 0; k < n; k++) begin
            if (style == 0) begin
                // unordered times
                send_key(KEY_AW'(k), $urandom(), rand_value(), rand_value(), rand_value());
            end else begin
                send_key(KEY_AW'(k), t, rand_value(), rand_value(), rand_value());
                // an occasional zero step gives equal key times
                if ($urandom_range(0, 9) != 0)
                    t = t + $urandom_range(1, maxstep);
            end
        end
        case ($urandom_range(0, 15))
            0:       cnt = '0;
            1:       cnt = CNT_W'(1);
            2:       cnt = CNT_W'($urandom_range(MAX_KEYS + 1, COUNT_TOP));
            3:       cnt = CNT_W'(COUNT_TOP);
            default: cnt = CNT_W'(n);
        endcase
        if (exact_count)
            cnt = CNT_W'(n);
        set_key_count(cnt);
        eff = (cnt > MAX_KEYS) ? MAX_KEYS : int'(cnt);
        n_q = $urandom_range(6, 20);
        for (k = 0; k < n_q; k++) begin
            if ($urandom_range(0, 15) == 0)
                send_key(KEY_AW'($urandom_range(0, 63)), $urandom(), rand_value(),
                         rand_value(), rand_value());
            send_query(pick_query(eff));
        end
    endtask

    initial begin : stimulus
        int ph;
        int goal;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table
        send_query(32'h0);
        send_query(32'hFFFF_FFFF);
        // single key, any time
        send_key(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        set_key_count(CNT_W'(1));
        send_query(32'h0);
        send_query(32'hFFFF_FFFF);
        // four keys with full-range deltas and two equal times
        send_key(6'd1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_key(6'd2, 32'h0003_0000, 32'h0, 32'h1234_5678, 32'h8000_0000);
        send_key(6'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        set_key_count(CNT_W'(4));
        send_query(32'h0);
        send_query(32'h0001_0000);
        send_query(32'h0002_0000);
        send_query(32'h0002_FFFF);
        send_query(32'h0003_0000);
        send_query(32'hFFFF_FFFE);
        send_query(32'hFFFF_FFFF);
        // past the end of a two-key table
        set_key_count(CNT_W'(2));
        send_query(32'h0003_0000);

        for (ph = 0; ph < 3; ph++) begin
            snd_idle_pct = snd_plan[ph];
            rcv_idle_pct = rcv_plan[ph];
            if (ph == 2)
                hold_request = 1'b1;
            goal = sent_items + ITEMS_PER_PHASE;
            while (sent_items < goal) begin
                if (!table_full) begin
                    // fill every slot first so no stale entry is ever read
                    run_sequence(MAX_KEYS, 1'b1);
                    table_full = 1'b1;
                end else if ($urandom_range(0, 9) == 0) begin
                    run_sequence(MAX_KEYS, 1'b0);
                end else begin
                    run_sequence($urandom_range(2, 8), 1'b0);
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
